// ===== rtl/core/pn3_pkg.sv =====
// Package for the 3D gradient noise block: shared constants, operation codes
// and gradient selection codes. No dependencies.
package pn3_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_SIZE = 256;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int CELL_W  = 8;
    localparam int PERM_W  = 8;
    localparam int OUT_W   = 18;

    // Output saturation limits (Q2.15)
    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;
    localparam int OUT_FRAC = 15;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    typedef enum logic {
        OP_EVAL = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // Gradient selection codes (low four hash bits)
    localparam logic [3:0] GRAD_U_Y_FROM = 4'd8;
    localparam logic [3:0] GRAD_V_Y_BELOW = 4'd4;
    localparam logic [3:0] GRAD_V_X_A    = 4'd12;
    localparam logic [3:0] GRAD_V_X_B    = 4'd14;

    // Width of one queue entry for a given fraction width
    function automatic int entry_width(input int frac_bits);
        return 1 + 3 * CELL_W + 3 * frac_bits + 2 * PERM_W;
    endfunction

endpackage

// ===== rtl/core/pn3_front.sv =====
// Front stage: takes input transactions, splits coordinates into cell and
// fraction, packs the entry for the queue. Depends on pn3_pkg.
module pn3_front #(
    parameter int FRAC_BITS = pn3_pkg::DEF_FRAC_BITS,
    parameter int ENTRY_W   = pn3_pkg::entry_width(pn3_pkg::DEF_FRAC_BITS)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic signed [pn3_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [pn3_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [pn3_pkg::COORD_W-1:0] s_coord_z,
    input  logic [pn3_pkg::PERM_W-1:0]         s_entry_index,
    input  logic [pn3_pkg::PERM_W-1:0]         s_entry_value,
    output logic                               q_valid,
    input  logic                               q_ready,
    output logic [ENTRY_W-1:0]                 q_data
);

    logic               valid_reg;
    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] data_next;
    logic               is_load;

    // Classify and split fields
    always_comb begin
        is_load   = (pn3_pkg::op_t'(s_operation) == pn3_pkg::OP_LOAD);
        data_next = {is_load,
                     s_coord_x[FRAC_BITS +: pn3_pkg::CELL_W],
                     s_coord_y[FRAC_BITS +: pn3_pkg::CELL_W],
                     s_coord_z[FRAC_BITS +: pn3_pkg::CELL_W],
                     s_coord_x[FRAC_BITS-1:0],
                     s_coord_y[FRAC_BITS-1:0],
                     s_coord_z[FRAC_BITS-1:0],
                     s_entry_index,
                     s_entry_value};
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    // Holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/pn3_queue.sv =====
// Short queue between the front and back stages.
// Depends on pn3_pkg for depth and pointer widths.
module pn3_queue #(
    parameter int DATA_W = pn3_pkg::entry_width(pn3_pkg::DEF_FRAC_BITS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0]          mem [pn3_pkg::QUEUE_DEPTH];
    logic [pn3_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [pn3_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [pn3_pkg::QCNT_W-1:0] count_reg;
    logic [pn3_pkg::QCNT_W-1:0] count_next;
    logic                       push;
    logic                       pop;

    assign in_ready  = (count_reg != pn3_pkg::QCNT_W'(pn3_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

`ifndef SYNTH
    a_ptr_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg[pn3_pkg::QPTR_W-1:0] == pn3_pkg::QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on pop");
`endif

endmodule

// ===== rtl/core/pn3_back.sv =====
// Back pipeline: three levels of permutation lookups, fade curves, corner
// gradients, seven interpolations and output rescaling. Depends on pn3_pkg.
module pn3_back #(
    parameter int TABLE_SIZE = pn3_pkg::DEF_TABLE_SIZE,
    parameter int FRAC_BITS  = pn3_pkg::DEF_FRAC_BITS,
    parameter int ENTRY_W    = pn3_pkg::entry_width(pn3_pkg::DEF_FRAC_BITS)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ENTRY_W-1:0]               in_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [pn3_pkg::OUT_W-1:0] m_noise_value
);

    localparam int F   = FRAC_BITS;
    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int FW  = F + 4;          // fade values
    localparam int GW  = F + 3;          // gradients
    localparam int LW  = F + 6;          // interpolated values
    localparam int PWD = 2 * F + 12;     // lerp products and rescaling
    localparam int QW  = 2 * F + 5;      // fade quadratic
    localparam int DN  = (F > pn3_pkg::OUT_FRAC) ? (F - pn3_pkg::OUT_FRAC) : 0;
    localparam int UP  = (F < pn3_pkg::OUT_FRAC) ? (pn3_pkg::OUT_FRAC - F) : 0;
    localparam int CW  = pn3_pkg::CELL_W;
    localparam int PW  = pn3_pkg::PERM_W;

    // Index reduction modulo the table size (values stay below 512)
    function automatic logic [IW-1:0] modt(input logic [8:0] v);
        logic [10:0] r;
        r = {2'b00, v};
        for (int k = 5; k >= 0; k--) begin
            if (int'(r) >= (TABLE_SIZE << k)) begin
                r = r - 11'(TABLE_SIZE << k);
            end
        end
        return r[IW-1:0];
    endfunction

    // Signed shift right, rounding half away from zero
    function automatic logic signed [PWD-1:0] rnd(input logic signed [PWD-1:0] v,
                                                  input int s);
        logic [PWD-1:0] mag;
        logic [PWD-1:0] half;
        if (s == 0) begin
            return v;
        end
        half = PWD'(1) << (s - 1);
        mag  = v[PWD-1] ? PWD'(-v) : PWD'(v);
        mag  = (mag + half) >> s;
        return v[PWD-1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Corner gradient dot product
    function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                  input logic signed [F+1:0] x,
                                                  input logic signed [F+1:0] y,
                                                  input logic signed [F+1:0] z);
        logic signed [GW-1:0] ue;
        logic signed [GW-1:0] ve;
        ue = (h < pn3_pkg::GRAD_U_Y_FROM) ? GW'(x) : GW'(y);
        if (h < pn3_pkg::GRAD_V_Y_BELOW) begin
            ve = GW'(y);
        end else if (h == pn3_pkg::GRAD_V_X_A || h == pn3_pkg::GRAD_V_X_B) begin
            ve = GW'(x);
        end else begin
            ve = GW'(z);
        end
        if (h[0]) ue = -ue;
        if (h[1]) ve = -ve;
        return ue + ve;
    endfunction

    // Linear interpolation a + round(t * (b - a))
    function automatic logic signed [LW-1:0] lerp(input logic [FW-1:0] t,
                                                  input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
        logic signed [LW:0]    d;
        logic signed [PWD-1:0] prod;
        d    = (LW+1)'(b) - (LW+1)'(a);
        prod = $signed({1'b0, t}) * d;
        return a + LW'(rnd(prod, F));
    endfunction

    // Fade multiply step, unsigned round to nearest
    function automatic logic [FW-1:0] fmul(input logic [FW-1:0] p,
                                           input logic [F-1:0] t);
        logic [QW-1:0] prod;
        prod = QW'(p) * QW'(t) + (QW'(1) << (F - 1));
        return FW'(prod >> F);
    endfunction

    logic adv;

    // Unpacked queue entry
    logic          e_ld;
    logic [CW-1:0] e_cx, e_cy, e_cz;
    logic [F-1:0]  e_fx, e_fy, e_fz;
    logic [PW-1:0] e_wi, e_wv;

    assign {e_ld, e_cx, e_cy, e_cz, e_fx, e_fy, e_fz, e_wi, e_wv} = in_data;
    assign adv      = !m_valid || m_ready;
    assign in_ready = adv;

    // Stage valid flags
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic ld1_reg, ld2_reg, ld3_reg;

    // Stage payloads
    logic [CW-1:0] cx1_reg, cy1_reg, cz1_reg, cy2_reg, cz2_reg, cz3_reg;
    logic [PW-1:0] wi1_reg, wv1_reg, wi2_reg, wv2_reg, wi3_reg, wv3_reg;
    logic [F-1:0]  fr1_reg [3];
    logic [F-1:0]  fr2_reg [3];
    logic [F-1:0]  fr3_reg [3];
    logic [F-1:0]  fr4_reg [3];
    logic [F-1:0]  fr5_reg [3];
    logic [2*F-1:0] sq2_reg [3];
    logic [FW-1:0] p0_3_reg [3];
    logic [FW-1:0] p1_4_reg [3];
    logic [FW-1:0] p2_5_reg [3];
    logic [FW-1:0] fade6_reg [3];
    logic [FW-1:0] fv7_reg, fw7_reg, fw8_reg;
    logic [PW-1:0] l1_reg [2];
    logic [PW-1:0] l2_lo [2];
    logic [PW-1:0] l2_hi [2];
    logic [PW-1:0] l3_lo [4];
    logic [PW-1:0] l3_hi [4];
    logic signed [GW-1:0] g5_reg [8];
    logic signed [GW-1:0] g6_reg [8];
    logic signed [LW-1:0] lx7_reg [4];
    logic signed [LW-1:0] ly8_reg [2];
    logic signed [LW-1:0] lz9_reg;
    logic                          m_valid_reg;
    logic signed [pn3_pkg::OUT_W-1:0] m_noise_reg;

    // Stage valid flags; loads leave after the last table level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            v7_reg <= 1'b0; v8_reg <= 1'b0; v9_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && !ld3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
            m_valid_reg <= v9_reg;
        end
    end

    // Payload through the table levels
    always_ff @(posedge aclk) begin
        if (adv) begin
            ld1_reg <= e_ld;
            cx1_reg <= e_cx; cy1_reg <= e_cy; cz1_reg <= e_cz;
            wi1_reg <= e_wi; wv1_reg <= e_wv;
            fr1_reg[0] <= e_fx; fr1_reg[1] <= e_fy; fr1_reg[2] <= e_fz;
            ld2_reg <= ld1_reg; cy2_reg <= cy1_reg; cz2_reg <= cz1_reg;
            wi2_reg <= wi1_reg; wv2_reg <= wv1_reg;
            ld3_reg <= ld2_reg; cz3_reg <= cz2_reg;
            wi3_reg <= wi2_reg; wv3_reg <= wv2_reg;
            fr2_reg <= fr1_reg;
            fr3_reg <= fr2_reg;
            fr4_reg <= fr3_reg;
            fr5_reg <= fr4_reg;
        end
    end

    // Level 1 table copy: perm(X), perm(X+1)
    logic [PW-1:0] mem1 [TABLE_SIZE];
    always_ff @(posedge aclk) begin
        if (adv) begin
            l1_reg[0] <= mem1[modt({1'b0, cx1_reg})];
            l1_reg[1] <= mem1[modt({1'b0, cx1_reg} + 9'd1)];
            if (v1_reg && ld1_reg) begin
                mem1[modt({1'b0, wi1_reg})] <= wv1_reg;
            end
        end
    end

    // Level 2 table copies: bank 0 at A, bank 1 at B
    for (genvar k = 0; k < 2; k++) begin : g_lvl2
        logic [PW-1:0] mem [TABLE_SIZE];
        logic [PW-1:0] lo_reg, hi_reg;
        logic [8:0]    base;
        assign base     = {1'b0, l1_reg[k]} + {1'b0, cy2_reg};
        assign l2_lo[k] = lo_reg;
        assign l2_hi[k] = hi_reg;
        always_ff @(posedge aclk) begin
            if (adv) begin
                lo_reg <= mem[modt(base)];
                hi_reg <= mem[modt(base + 9'd1)];
                if (v2_reg && ld2_reg) begin
                    mem[modt({1'b0, wi2_reg})] <= wv2_reg;
                end
            end
        end
    end

    // Level 3 table copies: banks at AA, BA, AB, BB give corner j and j+4
    for (genvar j = 0; j < 4; j++) begin : g_lvl3
        logic [PW-1:0] mem [TABLE_SIZE];
        logic [PW-1:0] lo_reg, hi_reg;
        logic [8:0]    base;
        assign base = {1'b0, (j >= 2) ? l2_hi[j % 2] : l2_lo[j % 2]} + {1'b0, cz3_reg};
        assign l3_lo[j] = lo_reg;
        assign l3_hi[j] = hi_reg;
        always_ff @(posedge aclk) begin
            if (adv) begin
                lo_reg <= mem[modt(base)];
                hi_reg <= mem[modt(base + 9'd1)];
                if (v3_reg && ld3_reg) begin
                    mem[modt({1'b0, wi3_reg})] <= wv3_reg;
                end
            end
        end
    end

    // Fade curve lanes, at most one multiply per stage
    logic [2*F-1:0] sq [3];
    logic [QW-1:0]  qv [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sq[a] = (2*F)'(fr1_reg[a]) * (2*F)'(fr1_reg[a]);
            qv[a] = (QW'(sq2_reg[a]) << 2) + (QW'(sq2_reg[a]) << 1)
                  + (QW'(10) << (2 * F))
                  - ((QW'(fr2_reg[a]) << (F + 4)) - (QW'(fr2_reg[a]) << F))
                  + (QW'(1) << (F - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                sq2_reg[a]   <= sq[a];
                p0_3_reg[a]  <= FW'(qv[a] >> F);
                p1_4_reg[a]  <= fmul(p0_3_reg[a], fr3_reg[a]);
                p2_5_reg[a]  <= fmul(p1_4_reg[a], fr4_reg[a]);
                fade6_reg[a] <= fmul(p2_5_reg[a], fr5_reg[a]);
            end
        end
    end

    // Corner gradients, hashes and fractions both at the fourth stage
    logic signed [F+1:0] cpos [3];
    logic signed [F+1:0] cneg [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cpos[a] = {2'b00, fr4_reg[a]};
            cneg[a] = {2'b11, fr4_reg[a]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                g5_reg[c]     <= grad(l3_lo[c][3:0],
                                      c[0] ? cneg[0] : cpos[0],
                                      c[1] ? cneg[1] : cpos[1],
                                      cpos[2]);
                g5_reg[c + 4] <= grad(l3_hi[c][3:0],
                                      c[0] ? cneg[0] : cpos[0],
                                      c[1] ? cneg[1] : cpos[1],
                                      cneg[2]);
            end
            g6_reg <= g5_reg;
        end
    end

    // Interpolation along x, y, z
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++) begin
                lx7_reg[c] <= lerp(fade6_reg[0], LW'(g6_reg[2*c]), LW'(g6_reg[2*c+1]));
            end
            fv7_reg    <= fade6_reg[1];
            fw7_reg    <= fade6_reg[2];
            ly8_reg[0] <= lerp(fv7_reg, lx7_reg[0], lx7_reg[1]);
            ly8_reg[1] <= lerp(fv7_reg, lx7_reg[2], lx7_reg[3]);
            fw8_reg    <= fw7_reg;
            lz9_reg    <= lerp(fw8_reg, ly8_reg[0], ly8_reg[1]);
        end
    end

    // Rescale to Q2.15 and saturate
    logic signed [PWD-1:0]            rs;
    logic signed [pn3_pkg::OUT_W-1:0] noise;
    always_comb begin
        rs = rnd(PWD'(lz9_reg), DN) <<< UP;
        if (rs > PWD'(pn3_pkg::OUT_MAX)) begin
            noise = pn3_pkg::OUT_W'(pn3_pkg::OUT_MAX);
        end else if (rs < PWD'(pn3_pkg::OUT_MIN)) begin
            noise = pn3_pkg::OUT_W'(pn3_pkg::OUT_MIN);
        end else begin
            noise = pn3_pkg::OUT_W'(rs);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_noise_reg <= noise;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_noise_value = m_noise_reg;

endmodule

// ===== rtl/core/perlin_noise_3d.sv =====
// Top level of the 3D gradient noise block: front stage, queue, back pipeline.
// Depends on pn3_pkg, pn3_front, pn3_queue and pn3_back.
//
// Evaluates improved 3D gradient noise, one transaction per clock when the
// output side keeps m_ready high. An evaluate transaction passes the front
// register, the queue, nine back stages and the output register; the three
// dependent permutation lookups and the four fade multiplies set the depth
// of the back stages. The table is held in seven copies, each read at two
// addresses per cycle; a load transaction writes each copy as it passes
// that copy's lookup stage, so loads and evaluations keep their order and
// a load returns no result. The table has no reset: load every entry an
// evaluation may touch before using it. Coordinates are signed fixed point
// with FRAC_BITS fraction bits; the result is signed Q2.15, saturated.
module perlin_noise_3d #(
    parameter int TABLE_SIZE = pn3_pkg::DEF_TABLE_SIZE,
    parameter int FRAC_BITS  = pn3_pkg::DEF_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic signed [pn3_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [pn3_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [pn3_pkg::COORD_W-1:0] s_coord_z,
    input  logic [pn3_pkg::PERM_W-1:0]         s_entry_index,
    input  logic [pn3_pkg::PERM_W-1:0]         s_entry_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pn3_pkg::OUT_W-1:0]   m_noise_value
);

    localparam int ENTRY_W = pn3_pkg::entry_width(FRAC_BITS);

    logic               fq_valid, fq_ready;
    logic [ENTRY_W-1:0] fq_data;
    logic               qb_valid, qb_ready;
    logic [ENTRY_W-1:0] qb_data;

    pn3_front #(
        .FRAC_BITS (FRAC_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    pn3_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    pn3_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .FRAC_BITS  (FRAC_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (qb_valid),
        .in_ready      (qb_ready),
        .in_data       (qb_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_noise_value (m_noise_value)
    );

endmodule

// ===== tb/tb_perlin_noise_3d.sv =====
// Self-checking testbench for perlin_noise_3d: table loads, noise evaluation,
// bursty sender and stalling receiver. Depends on pn3_pkg and the RTL.
`timescale 1ns / 100ps

module tb_perlin_noise_3d;

    localparam int FB = pn3_pkg::DEF_FRAC_BITS;
    localparam int N_RANDOM = 1380;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic s_operation;
    logic signed [31:0] s_coord_x, s_coord_y, s_coord_z;
    logic [7:0] s_entry_index, s_entry_value;
    logic m_valid;
    logic m_ready;
    logic signed [17:0] m_noise_value;

    perlin_noise_3d uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_coord_z(s_coord_z),
        .s_entry_index(s_entry_index), .s_entry_value(s_entry_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_noise_value(m_noise_value)
    );

    // One stimulus row; has_known marks a hand-typed expectation
    typedef struct {
        pn3_pkg::op_t op;
        logic [31:0] cx, cy, cz;
        logic [7:0] idx, val;
        bit has_known;
        logic signed [17:0] known;
    } point_row_t;

    logic [7:0] perm_shadow [256];
    logic signed [17:0] noise_expected_q [$];
    int mismatches;
    int noise_checked;
    longint cycles;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Signed shift right with rounding half away from zero
    function automatic longint round_div(longint v, int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0) return (v + h) >>> s;
        return -((-v + h) >>> s);
    endfunction

    function automatic longint fade_curve(longint t);
        longint h, q, p;
        h = longint'(1) << (FB - 1);
        q = 6 * t * t + (longint'(10) << (2 * FB)) - 15 * (t << FB);
        p = (q + h) >>> FB;
        for (int i = 0; i < 3; i++) p = (p * t + h) >>> FB;
        return p;
    endfunction

    function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
        logic [3:0] h;
        longint u, v;
        h = hash[3:0];
        u = (h < pn3_pkg::GRAD_U_Y_FROM) ? x : y;
        v = (h < pn3_pkg::GRAD_V_Y_BELOW) ? y
          : ((h == pn3_pkg::GRAD_V_X_A || h == pn3_pkg::GRAD_V_X_B) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic longint blend(longint t, longint a, longint b);
        return a + round_div(t * (b - a), FB);
    endfunction

    function automatic logic [7:0] perm_at(int i);
        return perm_shadow[i & 8'hFF];
    endfunction

    // Expected noise at a point, from the shadow table
    function automatic logic signed [17:0] noise_at(logic [31:0] cx, logic [31:0] cy,
                                                      logic [31:0] cz);
        int X, Y, Z, A, B, AA, AB, BA, BB;
        longint x, y, z, x1, y1, z1, u, v, w, r;
        X = cx[FB +: 8]; Y = cy[FB +: 8]; Z = cz[FB +: 8];
        x = cx[FB-1:0]; y = cy[FB-1:0]; z = cz[FB-1:0];
        x1 = x - (longint'(1) << FB);
        y1 = y - (longint'(1) << FB);
        z1 = z - (longint'(1) << FB);
        u = fade_curve(x); v = fade_curve(y); w = fade_curve(z);
        A = perm_at(X) + Y; AA = perm_at(A) + Z; AB = perm_at(A + 1) + Z;
        B = perm_at(X + 1) + Y; BA = perm_at(B) + Z; BB = perm_at(B + 1) + Z;
        r = blend(w,
            blend(v,
                blend(u, corner_dot(perm_at(AA), x, y, z), corner_dot(perm_at(BA), x1, y, z)),
                blend(u, corner_dot(perm_at(AB), x, y1, z),
                      corner_dot(perm_at(BB), x1, y1, z))),
            blend(v,
                blend(u, corner_dot(perm_at(AA + 1), x, y, z1),
                      corner_dot(perm_at(BA + 1), x1, y, z1)),
                blend(u, corner_dot(perm_at(AB + 1), x, y1, z1),
                      corner_dot(perm_at(BB + 1), x1, y1, z1))));
        if (FB > pn3_pkg::OUT_FRAC) r = round_div(r, FB - pn3_pkg::OUT_FRAC);
        else r = r << (pn3_pkg::OUT_FRAC - FB);
        if (r > pn3_pkg::OUT_MAX) r = pn3_pkg::OUT_MAX;
        if (r < pn3_pkg::OUT_MIN) r = pn3_pkg::OUT_MIN;
        return r[17:0];
    endfunction

    // Send one transaction; holds valid until accepted
    task automatic send_point(point_row_t row);
        s_valid <= 1'b1;
        s_operation <= row.op;
        s_coord_x <= row.cx; s_coord_y <= row.cy; s_coord_z <= row.cz;
        s_entry_index <= row.idx; s_entry_value <= row.val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (row.op == pn3_pkg::OP_LOAD) begin
            perm_shadow[row.idx] = row.val;
        end else begin
            if (row.has_known && row.known !== noise_at(row.cx, row.cy, row.cz))
                $display("directed row disagrees with predictor");
            noise_expected_q.push_back(row.has_known ? row.known
                                       : noise_at(row.cx, row.cy, row.cz));
        end
    endtask

    // Random gap between bursts; valid dropped only when a gap is taken
    task automatic sender_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        if ($urandom_range(0, 2) != 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    function automatic point_row_t load_row(int i, int v);
        point_row_t r;
        r = '{pn3_pkg::OP_LOAD, $urandom, $urandom, $urandom, i[7:0], v[7:0],
              1'b0, 18'sd0};
        return r;
    endfunction

    function automatic point_row_t eval_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            bit k, logic signed [17:0] kv);
        point_row_t r;
        r = '{pn3_pkg::OP_EVAL, x, y, z, 8'($urandom), 8'($urandom), k, kv};
        return r;
    endfunction

    // Receiver stall pattern and result check
    initial begin
        int phase;
        m_ready = 1'b0;
        phase = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (noise_expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %0d", m_noise_value);
                end else begin
                    logic signed [17:0] e;
                    e = noise_expected_q.pop_front();
                    noise_checked++;
                    if (m_noise_value !== e) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("noise mismatch: expected %0d actual %0d", e,
                                     m_noise_value);
                    end
                end
            end
            phase = (phase + 1) % 64;
            if (phase < 24) m_ready <= 1'b1;
            else if (phase < 40) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 1) != 0);
        end
    end

    // Cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        point_row_t directed [$];
        point_row_t row;
        int burst;
        int drain;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = pn3_pkg::OP_EVAL;
        s_coord_x = '0; s_coord_y = '0; s_coord_z = '0;
        s_entry_index = '0; s_entry_value = '0;
        mismatches = 0;
        noise_checked = 0;
        burst = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole table with zeros first so no read hits an unwritten entry
        for (int i = 0; i < 256; i++) begin
            send_point(load_row(i, 0));
            sender_gap(burst);
        end
        // All-zero table: hash 0 gives x+y, integer points give zero
        directed.push_back(eval_row(32'h0, 32'h0, 32'h0, 1'b1, 18'sd0));
        directed.push_back(eval_row(32'h7FFF_0000, 32'h8000_0000, 32'h0001_0000,
                                    1'b1, 18'sd0));
        directed.push_back(eval_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    1'b0, 18'sd0));
        directed.push_back(eval_row(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000,
                                    1'b0, 18'sd0));
        directed.push_back(eval_row(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                                    1'b0, 18'sd0));
        // Distinct values at both extremes of index and at the top of the value range
        directed.push_back(load_row(255, 255));
        directed.push_back(load_row(0, 15));
        directed.push_back(load_row(1, 12));
        directed.push_back(load_row(14, 14));
        directed.push_back(eval_row(32'h00FF_4000, 32'hFFFF_C000, 32'h0000_0001,
                                    1'b0, 18'sd0));
        directed.push_back(eval_row(32'hFFFF_0000, 32'h00FF_FFFF, 32'h7F00_FFFF,
                                    1'b0, 18'sd0));
        directed.push_back(eval_row(32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFF,
                                    1'b0, 18'sd0));
        foreach (directed[i]) begin
            send_point(directed[i]);
            sender_gap(burst);
        end

        // Random: mostly evaluations, some table reloads
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) < 2)
                row = load_row($urandom_range(0, 255), $urandom_range(0, 255));
            else begin
                row = eval_row($urandom, $urandom, $urandom, 1'b0, 18'sd0);
                case ($urandom_range(0, 5))
                    0: row.cx[15:0] = 16'h0000;
                    1: row.cy[15:0] = 16'hFFFF;
                    2: row.cz = {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000, 16'h0000};
                    default: ;
                endcase
            end
            send_point(row);
            sender_gap(burst);
        end
        s_valid <= 1'b0;

        while (noise_expected_q.size() != 0) @(posedge aclk);
        drain = 0;
        while (drain < 40) begin
            @(posedge aclk);
            drain++;
        end
        $display("covered %0d table loads and noise points, %0d results checked",
                 256 + directed.size() + N_RANDOM, noise_checked);
        if (mismatches == 0 && noise_expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("mismatches: %0d", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
